// ----- rtl/strmq_pkg.sv -----
// Shared types and constants of the sparse-table range-minimum engine.
package strmq_pkg;

   localparam int MaxLengthDefault  = 1024;
   localparam int LevelsDefault     = 11;
   localparam int ValueWidthDefault = 32;
   localparam int IndexWidth        = 10;
   localparam int ResultWidth       = 32;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_RANGE  = 2'd1,
      STATUS_ARRAY_FULL = 2'd2
   } status_type;

   // Operations the front end hands to the back end.
   typedef enum logic [1:0] {
      OP_REPLY  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

endpackage

// ----- rtl/strmq_front.sv -----
// Front end: accepts commands, checks them against the count, queues work.
module strmq_front import strmq_pkg::*; #(
   parameter int MAX_LENGTH  = MaxLengthDefault,
   parameter int LEVELS      = LevelsDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault,
   localparam int AW = $clog2(MAX_LENGTH),
   localparam int CW = $clog2(MAX_LENGTH + 1),
   localparam int LW = $clog2(LEVELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             kind,
   input  logic [VALUE_WIDTH-1:0] element_value,
   input  logic [IndexWidth-1:0]  range_left,
   input  logic [IndexWidth-1:0]  range_right,
   input  logic                   pop,
   output logic                   q_valid,
   output logic                   q_full,
   output op_type                 q_op,
   output status_type             q_status,
   output logic [VALUE_WIDTH-1:0] q_value,
   output logic [AW-1:0]          q_addr_a,
   output logic [AW-1:0]          q_addr_b,
   output logic [LW-1:0]          q_level
);

   localparam int Depth = 2;

   typedef struct packed {
      op_type                 op;
      status_type             status;
      logic [VALUE_WIDTH-1:0] value;
      logic [AW-1:0]          addr_a;
      logic [AW-1:0]          addr_b;
      logic [LW-1:0]          level;
   } entry_type;

   entry_type         queue_ff [Depth];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic [CW-1:0]     count_ff, count_in;
   entry_type         entry;
   logic [IndexWidth:0] span;
   logic [4:0]        msb;
   logic [LW-1:0]     lvl;
   logic [IndexWidth:0] second;
   logic              bad;

   // Floor log2 of the span by a priority scan over its bits.
   always_comb begin
      span = {1'b0, range_right} - {1'b0, range_left} + 1'b1;
      msb = '0;
      for (int i = 0; i <= IndexWidth; i++) begin
         if (span[i]) msb = 5'(i);
      end
      lvl = (int'(msb) >= LEVELS) ? LW'(LEVELS - 1) : LW'(msb);
      second = {1'b0, range_right} + 1'b1 - ((IndexWidth + 1)'(1) << lvl);
      bad = (range_left > range_right) || (int'(range_right) >= int'(count_ff));
   end

   always_comb begin
      entry = '{op: OP_REPLY, status: STATUS_OK, value: element_value,
                addr_a: AW'(range_left), addr_b: AW'(second), level: lvl};
      count_in = count_ff;
      case (kind)
         KIND_CLEAR: count_in = '0;
         KIND_APPEND: begin
            if (count_ff == CW'(MAX_LENGTH)) begin
               entry.status = STATUS_ARRAY_FULL;
            end else begin
               entry.op = OP_APPEND;
               entry.addr_a = AW'(count_ff);
               count_in = count_ff + 1'b1;
            end
         end
         KIND_QUERY: begin
            if (bad) entry.status = STATUS_BAD_RANGE;
            else entry.op = OP_QUERY;
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in = fill_ff + {1'b0, accept} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
         if (accept) count_ff <= count_in;
      end
      if (accept) queue_ff[wr_ptr_ff] <= entry;
   end

   assign q_valid  = fill_ff != 2'd0;
   assign q_full   = fill_ff == 2'(Depth);
   assign q_op     = queue_ff[rd_ptr_ff].op;
   assign q_status = queue_ff[rd_ptr_ff].status;
   assign q_value  = queue_ff[rd_ptr_ff].value;
   assign q_addr_a = queue_ff[rd_ptr_ff].addr_a;
   assign q_addr_b = queue_ff[rd_ptr_ff].addr_b;
   assign q_level  = queue_ff[rd_ptr_ff].level;

   assert property (@(posedge clock) disable iff (reset) !(q_full && accept && !pop))
      else $error("command queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_LENGTH))
      else $error("element count beyond capacity");

endmodule

// ----- rtl/strmq_back.sv -----
// Back end: owns the level store, runs the append chain and query reads.
module strmq_back import strmq_pkg::*; #(
   parameter int MAX_LENGTH  = MaxLengthDefault,
   parameter int LEVELS      = LevelsDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault,
   localparam int AW = $clog2(MAX_LENGTH),
   localparam int LW = $clog2(LEVELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  op_type                 q_op,
   input  status_type             q_status,
   input  logic [VALUE_WIDTH-1:0] q_value,
   input  logic [AW-1:0]          q_addr_a,
   input  logic [AW-1:0]          q_addr_b,
   input  logic [LW-1:0]          q_level,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [ResultWidth-1:0] rsp_min,
   output status_type             rsp_st
);

   localparam int SW = $clog2(LEVELS * MAX_LENGTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ_A, ST_READ_B, ST_CMP, ST_APPEND_A, ST_APPEND_B, ST_APPEND_W
   } state_type;

   state_type                 state_ff;
   logic signed [VALUE_WIDTH-1:0] mem [LEVELS * MAX_LENGTH];
   logic signed [VALUE_WIDTH-1:0] rdata_ff, hold_ff, minv;
   logic [SW-1:0]             raddr, waddr;
   logic                      rd_en, wr_en;
   logic signed [VALUE_WIDTH-1:0] wdata;
   logic [AW-1:0]             pos_ff, addr_b_ff;
   logic [LW-1:0]             lvl_ff;
   logic [AW:0]               start_w;
   logic                      rsp_valid_ff;
   logic [ResultWidth-1:0]    rsp_min_ff;
   status_type                rsp_st_ff;

   function automatic logic [SW-1:0] flat(input logic [LW-1:0] l, input logic [AW-1:0] a);
      flat = SW'(l) * SW'(MAX_LENGTH) + SW'(a);
   endfunction

   // Window of the next append level: starts at pos + 1 - 2^level.
   assign start_w = {1'b0, pos_ff} + 1'b1 - ((AW + 1)'(1) << (lvl_ff + 1'b1));
   assign minv = (rdata_ff < hold_ff) ? rdata_ff : hold_ff;

   always_comb begin
      rd_en = 1'b0;
      raddr = flat(lvl_ff, pos_ff);
      wr_en = 1'b0;
      waddr = flat(lvl_ff, pos_ff);
      wdata = minv;
      pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop = q_valid;
            if (q_valid && q_op == OP_QUERY) begin
               rd_en = 1'b1;
               raddr = flat(q_level, q_addr_a);
            end
            if (q_valid && q_op == OP_APPEND) begin
               wr_en = 1'b1;
               waddr = flat('0, q_addr_a);
               wdata = q_value;
            end
         end
         ST_READ_A: begin
            rd_en = 1'b1;
            raddr = flat(lvl_ff, addr_b_ff);
         end
         ST_APPEND_A: begin
            rd_en = 1'b1;
            raddr = flat(lvl_ff, AW'(start_w));
         end
         ST_APPEND_B: begin
            rd_en = 1'b1;
            raddr = flat(lvl_ff, AW'(start_w) + AW'((AW + 1)'(1) << lvl_ff));
         end
         ST_APPEND_W: begin
            wr_en = 1'b1;
            waddr = flat(lvl_ff + 1'b1, AW'(start_w));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  lvl_ff <= q_level;
                  pos_ff <= q_addr_a;
                  addr_b_ff <= q_addr_b;
                  case (q_op)
                     OP_QUERY: state_ff <= ST_READ_A;
                     OP_APPEND: begin
                        lvl_ff <= '0;
                        rsp_valid_ff <= 1'b1;
                        rsp_min_ff <= '0;
                        rsp_st_ff <= STATUS_OK;
                        // Level one gets a new entry once two elements are loaded.
                        if (LEVELS > 1 && q_addr_a != '0) state_ff <= ST_APPEND_A;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_min_ff <= '0;
                        rsp_st_ff <= q_status;
                     end
                  endcase
               end
            end
            ST_READ_A: begin
               hold_ff <= rdata_ff;
               state_ff <= ST_READ_B;
            end
            ST_READ_B: state_ff <= ST_CMP;
            ST_CMP: begin
               rsp_valid_ff <= 1'b1;
               rsp_min_ff <= ResultWidth'(minv);
               rsp_st_ff <= STATUS_OK;
               state_ff <= ST_IDLE;
            end
            ST_APPEND_A: state_ff <= ST_APPEND_B;
            ST_APPEND_B: begin
               hold_ff <= rdata_ff;
               state_ff <= ST_APPEND_W;
            end
            ST_APPEND_W: begin
               // Keep climbing while the next level exists and its window fits in the loaded elements.
               if (int'(lvl_ff) + 2 < LEVELS &&
                   ({1'b0, pos_ff} + 1'b1) >= ((AW + 1)'(1) << (lvl_ff + 2'd2))) begin
                  lvl_ff <= lvl_ff + 1'b1;
                  state_ff <= ST_APPEND_A;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min   = rsp_min_ff;
   assign rsp_st    = rsp_st_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ_A |=> state_ff == ST_READ_B)
      else $error("query read sequence broken");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |=> rsp_valid)
      else $error("query finished without a result");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("pop while busy");

endmodule

// ----- rtl/sparse_table_range_minimum.sv -----
// Top level of the sparse-table range-minimum engine.
//
//  channel   direction  handshake             fields
//  req       in         start && !busy        req_kind, req_element_value, req_range_*
//  rsp       out        rsp_valid, one cycle  rsp_minimum_value, rsp_status
//
// Clear, bad and full items answer from IDLE; a query runs READ_A, READ_B and CMP,
// set by the two reads of the one read port. An append writes level zero, then per
// higher level filled reads two entries, writes the minimum: one access a step.
// A two-entry queue lets the front take an item while the back still works.
// Reset is synchronous and clears the count and queue; the store needs no clearing.
module sparse_table_range_minimum import strmq_pkg::*; #(
   parameter int MAX_LENGTH  = MaxLengthDefault,
   parameter int LEVELS      = LevelsDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_kind,
   input  logic [VALUE_WIDTH-1:0] req_element_value,
   input  logic [IndexWidth-1:0]  req_range_left,
   input  logic [IndexWidth-1:0]  req_range_right,
   output logic                   rsp_valid,
   output logic [ResultWidth-1:0] rsp_minimum_value,
   output logic [1:0]             rsp_status
);

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(LEVELS);

   logic                   accept, pop, q_valid, q_full;
   op_type                 q_op;
   status_type             q_status, rsp_st;
   logic [VALUE_WIDTH-1:0] q_value;
   logic [AW-1:0]          q_addr_a, q_addr_b;
   logic [LW-1:0]          q_level;

   assign busy = q_full;
   assign accept = start && !busy;
   assign rsp_status = rsp_st;

   strmq_front #(.MAX_LENGTH(MAX_LENGTH), .LEVELS(LEVELS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock, .reset, .accept, .kind(req_kind), .element_value(req_element_value),
      .range_left(req_range_left), .range_right(req_range_right), .pop,
      .q_valid, .q_full, .q_op, .q_status, .q_value, .q_addr_a, .q_addr_b, .q_level);

   strmq_back #(.MAX_LENGTH(MAX_LENGTH), .LEVELS(LEVELS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_op, .q_status, .q_value, .q_addr_a, .q_addr_b,
      .q_level, .pop, .rsp_valid, .rsp_min(rsp_minimum_value), .rsp_st);

endmodule
